>>> rtl/sscc_pkg.sv
// Package for the slicing shape-curve combiner.
// Holds sizes, item kind codes and the sequencer state type; no dependencies.
package sscc_pkg;
  localparam int unsigned MaxShapes = 32;
  localparam int unsigned DimBits   = 20;
  localparam int unsigned IdxBits   = $clog2(MaxShapes);
  localparam int unsigned CntBits   = $clog2(MaxShapes + 1);

  typedef logic [DimBits-1:0] dim_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef enum logic [1:0] {
    KindLoadLeft  = 2'd0,
    KindLoadRight = 2'd1,
    KindLeaf      = 2'd2,
    KindCombine   = 2'd3
  } kind_e;

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StCurRd  = 10'b00_0000_0010,
    StCurWt  = 10'b00_0000_0100,
    StShift  = 10'b00_0000_1000,
    StPut    = 10'b00_0001_0000,
    StWalkRd = 10'b00_0010_0000,
    StWalkOp = 10'b00_0100_0000,
    StLeafA  = 10'b00_1000_0000,
    StLeafB  = 10'b01_0000_0000,
    StEmpty  = 10'b10_0000_0000
  } state_e;
endpackage

>>> rtl/slicing_shape_curve_combine.sv
// Top level of the slicing shape-curve combiner.
// Depends on sscc_pkg for sizes, kind codes and the state type.
//
// Loads can follow back to back and emit nothing; a load into a full list
// is dropped and the overflow flag is set until the next combine. A leaf
// emits its two orientations, wider first, and the block is ready again
// once the second is loaded into the output register. A combine with an
// empty child list emits one result marked empty and is done once that
// result is loaded into the output register. Any other combine sorts each
// child list in place with a stable insertion sort that uses one key
// comparator, one write port and one read port per list: inserting
// element i fetches it and its upper neighbor, moves each neighbor with a
// strictly smaller key down one slot and then writes the element into its
// slot. The walk then reads both lists together and emits one merged shape
// for each pair of entries it reads, at most ln+rn-1 of them. Each emit
// waits while the output register stays full. The block is not ready while
// a leaf or combine is in work.
module slicing_shape_curve_combine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [1:0]           kind_i,
  input  logic                 cut_i,
  input  sscc_pkg::dim_t       shape_width_i,
  input  sscc_pkg::dim_t       shape_height_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output sscc_pkg::dim_t       out_width_o,
  output sscc_pkg::dim_t       out_height_o,
  output sscc_pkg::idx_t       left_pick_o,
  output sscc_pkg::idx_t       right_pick_o,
  output logic                 last_o,
  output logic                 empty_res_o,
  output logic                 overflow_o
);
  import sscc_pkg::*;

  // Each list is a memory of (width, height) with a write port and a read port.
  logic [2*DimBits-1:0] lmem [MaxShapes];
  logic [2*DimBits-1:0] rmem [MaxShapes];
  logic [2*DimBits-1:0] lrd_q, rrd_q;

  state_e state_q, state_d;
  cnt_t   lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic   drop_q, drop_d, vert_q, vert_d, side_q, side_d;
  // Sort: i is the element being inserted, j its current slot.
  idx_t   i_q, i_d, j_q, j_d;
  // Held element during the sort, or the leaf dimensions.
  logic [2*DimBits-1:0] cur_q, cur_d;
  // Walk indices.
  idx_t   l_q, l_d, r_q, r_d;

  // Output register.
  logic   ovalid_q, ovalid_d;
  dim_t   ow_q, oh_q;
  idx_t   olp_q, orp_q;
  logic   olast_q, oempty_q, oovf_q;

  // Result that is loaded into the output register this cycle.
  logic   emit;
  dim_t   e_w, e_h;
  idx_t   e_lp, e_rp;
  logic   e_last, e_empty;

  logic out_free, place;
  assign ready_o  = (state_q == StIdle);
  assign out_free = !ovalid_q || ready_i;

  function automatic dim_t key_f(logic [2*DimBits-1:0] s, logic v);
    key_f = v ? s[DimBits-1:0] : s[2*DimBits-1:DimBits];
  endfunction

  function automatic dim_t sat_f(dim_t a, dim_t b);
    logic [DimBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_f = s[DimBits] ? {DimBits{1'b1}} : s[DimBits-1:0];
  endfunction

  // Memory port: one write address; the load kind or the active side selects the list.
  logic                 we;
  idx_t                 waddr, lraddr, rraddr;
  logic [2*DimBits-1:0] wdata;
  logic                 wsel_right;

  always_ff @(posedge clk_i) begin
    if (we && !wsel_right) lmem[waddr] <= wdata;
    if (we && wsel_right)  rmem[waddr] <= wdata;
    lrd_q <= lmem[lraddr];
    rrd_q <= rmem[rraddr];
  end

  cnt_t ncnt;
  assign ncnt = side_q ? rcnt_q : lcnt_q;

  logic [2*DimBits-1:0] rd_side;
  assign rd_side = side_q ? rrd_q : lrd_q;

  // Leaf orientations from the held dimensions.
  dim_t leaf_big, leaf_sml;
  assign leaf_big = (cur_q[2*DimBits-1:DimBits] > cur_q[DimBits-1:0])
                    ? cur_q[2*DimBits-1:DimBits] : cur_q[DimBits-1:0];
  assign leaf_sml = (cur_q[2*DimBits-1:DimBits] >= cur_q[DimBits-1:0])
                    ? cur_q[DimBits-1:0] : cur_q[2*DimBits-1:DimBits];

  // Walk arithmetic on the registered reads.
  dim_t lk, rk, mw, mh;
  logic adv_l, adv_r, walk_end;
  cnt_t nl, nr;
  assign lk       = key_f(lrd_q, vert_q);
  assign rk       = key_f(rrd_q, vert_q);
  assign adv_l    = lk >= rk;
  assign adv_r    = lk <= rk;
  assign nl       = cnt_t'(l_q) + cnt_t'(adv_l);
  assign nr       = cnt_t'(r_q) + cnt_t'(adv_r);
  assign walk_end = (nl >= lcnt_q) || (nr >= rcnt_q);
  always_comb begin
    if (vert_q) begin
      mw = sat_f(lrd_q[2*DimBits-1:DimBits], rrd_q[2*DimBits-1:DimBits]);
      mh = (lrd_q[DimBits-1:0] > rrd_q[DimBits-1:0]) ? lrd_q[DimBits-1:0]
                                                      : rrd_q[DimBits-1:0];
    end else begin
      mw = (lrd_q[2*DimBits-1:DimBits] > rrd_q[2*DimBits-1:DimBits])
           ? lrd_q[2*DimBits-1:DimBits] : rrd_q[2*DimBits-1:DimBits];
      mh = sat_f(lrd_q[DimBits-1:0], rrd_q[DimBits-1:0]);
    end
  end

  always_comb begin
    state_d    = state_q;
    lcnt_d     = lcnt_q;
    rcnt_d     = rcnt_q;
    drop_d     = drop_q;
    vert_d     = vert_q;
    side_d     = side_q;
    i_d        = i_q;
    j_d        = j_q;
    l_d        = l_q;
    r_d        = r_q;
    cur_d      = cur_q;
    we         = 1'b0;
    wsel_right = side_q;
    waddr      = j_q;
    wdata      = cur_q;
    lraddr     = i_q;
    rraddr     = i_q;
    place      = 1'b0;
    emit       = 1'b0;
    e_w        = '0;
    e_h        = '0;
    e_lp       = '0;
    e_rp       = '0;
    e_last     = 1'b0;
    e_empty    = 1'b0;

    case (state_q)
      StIdle: begin
        if (valid_i) begin
          case (kind_e'(kind_i))
            KindLoadLeft: begin
              if (lcnt_q < cnt_t'(MaxShapes)) begin
                we         = 1'b1;
                wsel_right = 1'b0;
                waddr      = lcnt_q[IdxBits-1:0];
                wdata      = {shape_width_i, shape_height_i};
                lcnt_d     = lcnt_q + cnt_t'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            KindLoadRight: begin
              if (rcnt_q < cnt_t'(MaxShapes)) begin
                we         = 1'b1;
                wsel_right = 1'b1;
                waddr      = rcnt_q[IdxBits-1:0];
                wdata      = {shape_width_i, shape_height_i};
                rcnt_d     = rcnt_q + cnt_t'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            KindLeaf: begin
              cur_d   = {shape_width_i, shape_height_i};
              state_d = StLeafA;
            end
            default: begin
              vert_d = cut_i;
              l_d    = '0;
              r_d    = '0;
              i_d    = idx_t'(1);
              j_d    = idx_t'(1);
              if ((lcnt_q == cnt_t'(0)) || (rcnt_q == cnt_t'(0))) begin
                state_d = StEmpty;
              end else if (lcnt_q > cnt_t'(1)) begin
                side_d  = 1'b0;
                state_d = StCurRd;
              end else if (rcnt_q > cnt_t'(1)) begin
                side_d  = 1'b1;
                state_d = StCurRd;
              end else begin
                state_d = StWalkRd;
              end
            end
          endcase
        end
      end
      StCurRd: state_d = StCurWt;
      StCurWt: begin
        // The held element arrives; fetch its upper neighbor.
        cur_d   = rd_side;
        lraddr  = j_q - idx_t'(1);
        rraddr  = j_q - idx_t'(1);
        state_d = StShift;
      end
      StShift: begin
        if (key_f(rd_side, vert_q) < key_f(cur_q, vert_q)) begin
          // Move the neighbor down one slot and fetch the next one.
          we    = 1'b1;
          wdata = rd_side;
          j_d   = j_q - idx_t'(1);
          if (j_q == idx_t'(1)) begin
            state_d = StPut;
          end else begin
            lraddr = j_q - idx_t'(2);
            rraddr = j_q - idx_t'(2);
          end
        end else begin
          we    = 1'b1;
          place = 1'b1;
        end
      end
      StPut: begin
        we    = 1'b1;
        place = 1'b1;
      end
      StWalkRd: begin
        lraddr  = l_q;
        rraddr  = r_q;
        state_d = StWalkOp;
      end
      StWalkOp: begin
        // Keep reading the same entries so the data holds while stalled.
        lraddr = l_q;
        rraddr = r_q;
        if (out_free) begin
          emit   = 1'b1;
          e_w    = mw;
          e_h    = mh;
          e_lp   = l_q;
          e_rp   = r_q;
          e_last = walk_end;
          l_d    = nl[IdxBits-1:0];
          r_d    = nr[IdxBits-1:0];
          if (walk_end) begin
            lcnt_d  = '0;
            rcnt_d  = '0;
            drop_d  = 1'b0;
            state_d = StIdle;
          end else begin
            state_d = StWalkRd;
          end
        end
      end
      StLeafA: begin
        if (out_free) begin
          emit    = 1'b1;
          e_w     = leaf_big;
          e_h     = leaf_sml;
          state_d = StLeafB;
        end
      end
      StLeafB: begin
        if (out_free) begin
          emit    = 1'b1;
          e_w     = leaf_sml;
          e_h     = leaf_big;
          e_last  = 1'b1;
          state_d = StIdle;
        end
      end
      StEmpty: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          e_empty = 1'b1;
          lcnt_d  = '0;
          rcnt_d  = '0;
          drop_d  = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // The held element has been written; go on with the next one, the other
    // list, or the walk.
    if (place) begin
      if (cnt_t'(i_q) + cnt_t'(1) < ncnt) begin
        i_d     = i_q + idx_t'(1);
        j_d     = i_q + idx_t'(1);
        state_d = StCurRd;
      end else if (!side_q && (rcnt_q > cnt_t'(1))) begin
        side_d  = 1'b1;
        i_d     = idx_t'(1);
        j_d     = idx_t'(1);
        state_d = StCurRd;
      end else begin
        state_d = StWalkRd;
      end
    end
  end

  assign ovalid_d = emit || (ovalid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      lcnt_q   <= '0;
      rcnt_q   <= '0;
      drop_q   <= 1'b0;
      vert_q   <= 1'b0;
      side_q   <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      l_q      <= '0;
      r_q      <= '0;
      cur_q    <= '0;
      ovalid_q <= 1'b0;
      ow_q     <= '0;
      oh_q     <= '0;
      olp_q    <= '0;
      orp_q    <= '0;
      olast_q  <= 1'b0;
      oempty_q <= 1'b0;
      oovf_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      lcnt_q   <= lcnt_d;
      rcnt_q   <= rcnt_d;
      drop_q   <= drop_d;
      vert_q   <= vert_d;
      side_q   <= side_d;
      i_q      <= i_d;
      j_q      <= j_d;
      l_q      <= l_d;
      r_q      <= r_d;
      cur_q    <= cur_d;
      ovalid_q <= ovalid_d;
      if (emit) begin
        ow_q     <= e_w;
        oh_q     <= e_h;
        olp_q    <= e_lp;
        orp_q    <= e_rp;
        olast_q  <= e_last;
        oempty_q <= e_empty;
        oovf_q   <= drop_q;
      end
    end
  end

  assign valid_o      = ovalid_q;
  assign out_width_o  = ow_q;
  assign out_height_o = oh_q;
  assign left_pick_o  = olp_q;
  assign right_pick_o = orp_q;
  assign last_o       = olast_q;
  assign empty_res_o  = oempty_q;
  assign overflow_o   = oovf_q;

endmodule

>>> sim/slicing_shape_curve_combine_tb.sv
// Self-checking testbench for the slicing shape-curve combiner.
// Depends on sscc_pkg and the slicing_shape_curve_combine RTL only.
`timescale 1ns / 1ps

module slicing_shape_curve_combine_tb;
  import sscc_pkg::*;

  typedef struct packed {
    logic [19:0] width;
    logic [19:0] height;
    logic [4:0]  lpick;
    logic [4:0]  rpick;
    logic        last;
    logic        empty;
    logic        ovf;
  } shape_res_t;

  typedef struct {
    logic [19:0] w;
    logic [19:0] h;
  } shape_t;

  // The scoreboard keeps its own copy of both child lists and of the drop
  // flag, and turns every accepted item into the shapes it should produce.
  class shape_scoreboard;
    shape_t     lefts[$];
    shape_t     rights[$];
    bit         dropped;
    shape_res_t pending[$];
    int         mismatches;

    function logic [19:0] sat_sum(logic [19:0] a, logic [19:0] b);
      logic [20:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[20] ? 20'hFFFFF : s[19:0];
    endfunction

    function logic [19:0] key_of(shape_t s, bit vert);
      return vert ? s.h : s.w;
    endfunction

    // Stable descending sort: an entry moves up only past strictly smaller keys.
    function void sort_list(ref shape_t a[$], input bit vert);
      shape_t cur;
      int j;
      for (int i = 1; i < a.size(); i++) begin
        cur = a[i];
        j = i;
        while (j > 0 && key_of(a[j-1], vert) < key_of(cur, vert)) begin
          a[j] = a[j-1];
          j--;
        end
        a[j] = cur;
      end
    endfunction

    function void add_expect(logic [19:0] w, logic [19:0] h, int lp, int rp,
                             bit last, bit empty);
      shape_res_t r;
      r.width = w; r.height = h; r.lpick = lp[4:0]; r.rpick = rp[4:0];
      r.last = last; r.empty = empty; r.ovf = dropped;
      pending.insert(pending.size(), r);
    endfunction

    function void note_item(logic [1:0] kind, bit cut, shape_t s);
      shape_t ls[$];
      shape_t rs[$];
      int l, r, nl, nr;
      logic [19:0] ow, oh, lk, rk, big, sml;
      case (kind)
        KindLoadLeft: begin
          if (lefts.size() < int'(MaxShapes)) lefts.insert(lefts.size(), s);
          else dropped = 1;
        end
        KindLoadRight: begin
          if (rights.size() < int'(MaxShapes)) rights.insert(rights.size(), s);
          else dropped = 1;
        end
        KindLeaf: begin
          big = (s.w > s.h) ? s.w : s.h;
          sml = (s.w >= s.h) ? s.h : s.w;
          add_expect(big, sml, 0, 0, 0, 0);
          add_expect(sml, big, 0, 0, 1, 0);
        end
        default: begin
          if (lefts.size() == 0 || rights.size() == 0) begin
            add_expect(20'h0, 20'h0, 0, 0, 1, 1);
          end else begin
            ls = lefts;
            rs = rights;
            sort_list(ls, cut);
            sort_list(rs, cut);
            l = 0; r = 0;
            while (l < ls.size() && r < rs.size()) begin
              lk = key_of(ls[l], cut);
              rk = key_of(rs[r], cut);
              if (cut) begin
                ow = sat_sum(ls[l].w, rs[r].w);
                oh = (ls[l].h > rs[r].h) ? ls[l].h : rs[r].h;
              end else begin
                ow = (ls[l].w > rs[r].w) ? ls[l].w : rs[r].w;
                oh = sat_sum(ls[l].h, rs[r].h);
              end
              nl = l + ((lk >= rk) ? 1 : 0);
              nr = r + ((lk <= rk) ? 1 : 0);
              add_expect(ow, oh, l, r, (nl >= ls.size() || nr >= rs.size()), 0);
              l = nl;
              r = nr;
            end
          end
          lefts.delete();
          rights.delete();
          dropped = 0;
        end
      endcase
    endfunction

    function void check_shape(shape_res_t got);
      shape_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected shape %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        valid_in, ready_out, valid_out, ready_in;
  logic [1:0]  kind;
  logic        cut;
  logic [19:0] shape_w, shape_h;
  logic [19:0] out_w, out_h;
  logic [4:0]  lpick, rpick;
  logic        olast, oempty, oovf;
  shape_res_t  got;
  logic        sink_hold;   // set while the receiver is forced to stall
  bit          sink_random;

  shape_scoreboard sb;

  assign got = {out_w, out_h, lpick, rpick, olast, oempty, oovf};

  slicing_shape_curve_combine i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .valid_i       (valid_in),
    .ready_o       (ready_out),
    .kind_i        (kind),
    .cut_i         (cut),
    .shape_width_i (shape_w),
    .shape_height_i(shape_h),
    .valid_o       (valid_out),
    .ready_i       (ready_in),
    .out_width_o   (out_w),
    .out_height_o  (out_h),
    .left_pick_o   (lpick),
    .right_pick_o  (rpick),
    .last_o        (olast),
    .empty_res_o   (oempty),
    .overflow_o    (oovf)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, occasionally a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Dimension with a bias toward extremes and repeated keys so ties happen.
  function automatic logic [19:0] rand_dim();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 20'hFFFFF;
    if (p == 1) return 20'h0;
    if (p < 5) return 20'($urandom_range(0, 7));
    if (p < 7) return 20'($urandom_range(20'h80000, 20'hFFFFF));
    return 20'($urandom());
  endfunction

  // Present one item at the falling edge and hold it until accepted. Valid
  // stays high after acceptance until the next item or an idle stretch.
  task automatic send_item(logic [1:0] k, bit c, logic [19:0] w, logic [19:0] h);
    shape_t s;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      valid_in = 1'b0;
      repeat (gap) @(negedge clk);
    end
    valid_in = 1'b1;
    kind = k; cut = c; shape_w = w; shape_h = h;
    do @(posedge clk); while (ready_out !== 1'b1);
    s.w = w; s.h = h;
    sb.note_item(k, c, s);
    @(negedge clk);
  endtask

  // Loads a node's children (a few shapes each, sometimes more) and combines.
  task automatic send_node(int nl, int nr, bit c);
    int order;
    int total;
    total = nl + nr;
    for (int i = 0; i < total; i++) begin
      order = $urandom_range(0, 1);
      if ((order != 0 && nl > 0) || nr == 0) begin
        send_item(KindLoadLeft, rand_bit(), rand_dim(), rand_dim());
        nl--;
      end else begin
        send_item(KindLoadRight, rand_bit(), rand_dim(), rand_dim());
        nr--;
      end
    end
    send_item(KindCombine, c, rand_dim(), rand_dim());
  endtask

  task automatic wait_drained();
    valid_in = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls unless held off by the stimulus process.
  always @(negedge clk) begin
    if (!rst_n || sink_hold) ready_in <= 0;
    else if (!sink_random) ready_in <= 1;
    else ready_in <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    if (rst_n && valid_out === 1'b1 && ready_in === 1'b1) sb.check_shape(got);
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int nodes;
    sb = new();
    rst_n = 0; valid_in = 0; kind = 0; cut = 0;
    shape_w = 0; shape_h = 0; sink_hold = 0; sink_random = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // Directed: leaves at the extremes, empty combines, a tie-heavy node.
    send_item(KindLeaf, 0, 20'hFFFFF, 20'h0);
    send_item(KindLeaf, 1, 20'h0, 20'hFFFFF);
    send_item(KindLeaf, 0, 20'h5, 20'h5);
    send_item(KindCombine, 0, 0, 0);
    send_item(KindLoadLeft, 0, 20'h3, 20'h4);
    send_item(KindCombine, 1, 0, 0);
    send_item(KindLoadRight, 1, 20'hFFFFF, 20'hFFFFF);
    send_item(KindCombine, 0, 0, 0);
    send_item(KindLoadLeft, 0, 20'hFFFFF, 20'hFFFFF);
    send_item(KindLoadLeft, 0, 20'h2, 20'h7);
    send_item(KindLoadRight, 1, 20'hFFFFF, 20'hFFFFF);
    send_item(KindLoadRight, 1, 20'h2, 20'h9);
    send_item(KindCombine, 0, 0, 0);
    send_item(KindLoadLeft, 0, 20'h80000, 20'h80000);
    send_item(KindLoadRight, 0, 20'h80000, 20'h80000);
    send_item(KindLoadRight, 0, 20'h7, 20'h80000);
    send_item(KindCombine, 1, 0, 0);
    // Overfill both lists so loads are dropped and flagged, leaf shows flag.
    sink_random = 1;
    for (int i = 0; i < int'(MaxShapes) + 2; i++) begin
      send_item(KindLoadLeft, 0, rand_dim(), rand_dim());
      send_item(KindLoadRight, 1, rand_dim(), rand_dim());
    end
    send_item(KindLeaf, 0, 20'h1, 20'h2);
    send_item(KindCombine, 1, 0, 0);

    // The sender pauses until every shape has come back.
    wait_drained();

    // Long receiver stall while the sender keeps offering items.
    fork
      begin
        sink_hold = 1;
        repeat (300) @(negedge clk);
        sink_hold = 0;
      end
      begin
        for (int i = 0; i < 6; i++) send_item(KindLeaf, 0, rand_dim(), rand_dim());
        send_node(3, 2, 1);
      end
    join

    // Random nodes: mostly small lists, a few full, some noise.
    nodes = 0;
    while (nodes < 40) begin
      case ($urandom_range(0, 9))
        0, 1: send_item(KindLeaf, rand_bit(), rand_dim(), rand_dim());
        2: send_item(2'($urandom_range(0, 3)), rand_bit(), rand_dim(), rand_dim());
        3: send_node($urandom_range(0, 32), $urandom_range(0, 33), rand_bit());
        default: send_node($urandom_range(1, 5), $urandom_range(1, 5), rand_bit());
      endcase
      nodes++;
    end

    wait_drained();
    repeat (200) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
